// File: design/mld_pkg.sv
// mld_pkg: shared constants and types for the multichannel level debouncer
// no dependencies
`default_nettype none

package mld_pkg;

  localparam int unsigned MAX_CH     = 10;
  localparam int unsigned PERIOD_W   = 8;
  localparam int unsigned HOLD_W     = 8;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SAMPLE_PERIOD_RST = 100;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [MAX_CH-1:0]     ch_mask_t;
  typedef logic [HOLD_W-1:0]     hold_t;
  typedef logic [PERIOD_W-1:0]   period_t;

  // register indexes of the configuration port
  localparam cfg_idx_t REG_SAMPLE_PERIOD = 2'd0;
  localparam cfg_idx_t REG_DEBOUNCE_LOW  = 2'd1;
  localparam cfg_idx_t REG_DEBOUNCE_HIGH = 2'd2;

endpackage : mld_pkg

`default_nettype wire

// File: design/multichannel_level_debouncer_core.sv
// multichannel_level_debouncer_core: per-channel counter debounce filter, top level
// depends on mld_pkg
//
// Every accepted word on the in_ channel is one timebase tick with the raw
// levels of up to ten sensors. A tick counter takes a sample every
// sample_period ticks; on a sample each channel either reloads its hold
// counter (level changed) or counts it down and confirms the level at zero.
// Each accepted word gives exactly one out_ word: the confirmed mask and a
// flag saying whether that tick sampled.
// The output is registered: the whole update sits between the state registers
// and the output register, and a new word can be taken every cycle while out_stall is low.
// The output register is the only buffer: in_stall rises only while a word
// sits in it and out_stall is high, so a stalled receiver holds the input
// back without losing or repeating anything.
// Reset (rst_n low, synchronous) empties the output register, clears the
// tick counter, levels, hold counters and confirmed mask, sets sample_period
// to 100 and all debounce times to 0. Configuration is written through
// cfg_we / cfg_index / cfg_data while the block is idle; debounce time
// changes only take effect at a channel's next level change.
`default_nettype none

module multichannel_level_debouncer_core
  import mld_pkg::*;
#(
  parameter int unsigned CHANNELS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [9:0]            in_raw_levels,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [9:0]                 out_confirmed_levels,
  output logic                       out_sampled
);

  localparam ch_mask_t CH_MASK = ch_mask_t'((11'd1 << CHANNELS) - 11'd1);

  // configuration
  period_t                 sample_period_r;
  logic [CFG_DATA_W-1:0]   dbt_low_r;
  logic [CFG_DATA_W-1:0]   dbt_high_r;

  // channel state
  period_t                 tick_count_r, tick_count_nxt;
  ch_mask_t                last_level_r, last_level_nxt;
  ch_mask_t                confirmed_r,  confirmed_nxt;
  hold_t                   hold_r   [MAX_CH];
  hold_t                   hold_nxt [MAX_CH];

  // output register
  logic                    out_valid_r;
  ch_mask_t                out_levels_r;
  logic                    out_sampled_r;

  logic                    in_acc;
  period_t                 tick_inc;
  logic                    sample;
  logic [2*CFG_DATA_W-1:0] dbt_all;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign dbt_all  = {dbt_high_r, dbt_low_r};

  always_comb begin
    tick_inc = (tick_count_r < sample_period_r) ? tick_count_r + period_t'(1) : tick_count_r;
    sample   = (tick_inc >= sample_period_r);
    tick_count_nxt = sample ? '0 : tick_inc;
  end

  always_comb begin
    last_level_nxt = last_level_r;
    confirmed_nxt  = confirmed_r;
    for (int i = 0; i < MAX_CH; i++) begin
      hold_nxt[i] = hold_r[i];
      if (i >= CHANNELS) begin
        last_level_nxt[i] = 1'b0;
        confirmed_nxt[i]  = 1'b0;
        hold_nxt[i]       = '0;
      end else if (sample) begin
        if (last_level_r[i] != in_raw_levels[i]) begin
          last_level_nxt[i] = in_raw_levels[i];
          hold_nxt[i]       = dbt_all[8*i +: 8];
        end else if (hold_r[i] != '0) begin
          hold_nxt[i] = hold_r[i] - hold_t'(1);
          // confirm as the counter runs out
          if (hold_r[i] == hold_t'(1)) begin
            confirmed_nxt[i] = in_raw_levels[i];
          end
        end else begin
          confirmed_nxt[i] = in_raw_levels[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= period_t'(SAMPLE_PERIOD_RST);
      dbt_low_r       <= '0;
      dbt_high_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_PERIOD: sample_period_r <= cfg_data[PERIOD_W-1:0];
        REG_DEBOUNCE_LOW:  dbt_low_r       <= cfg_data;
        REG_DEBOUNCE_HIGH: dbt_high_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      last_level_r <= '0;
      confirmed_r  <= '0;
      for (int i = 0; i < MAX_CH; i++) begin
        hold_r[i] <= '0;
      end
    end else if (in_acc) begin
      tick_count_r <= tick_count_nxt;
      last_level_r <= last_level_nxt;
      confirmed_r  <= confirmed_nxt;
      for (int i = 0; i < MAX_CH; i++) begin
        hold_r[i] <= hold_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_levels_r  <= confirmed_nxt & CH_MASK;
      out_sampled_r <= sample;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_confirmed_levels = out_levels_r;
  assign out_sampled          = out_sampled_r;

`ifndef ASSERT_OFF
  a_tick_cleared_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && sample |=> tick_count_r == '0)
    else $error("tick counter not cleared after a sample");

  a_confirmed_hold_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !sample |=> confirmed_r == $past(confirmed_r))
    else $error("confirmed mask changed on a tick without a sample");

  a_out_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r && out_levels_r == confirmed_r)
    else $error("output word does not match the confirmed state");

  a_unused_channels_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (confirmed_r & ~CH_MASK) == '0)
    else $error("unused channel shows a confirmed level");
`endif

endmodule : multichannel_level_debouncer_core

`default_nettype wire
